// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the CRT pair combiner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CRT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/crtpc_pkg.sv =====
// Shared constants and divider control types for the CRT pair combiner.
package crtpc_pkg;

    localparam int MODULUS_WIDTH_DEF = 32;
    localparam int FIELD_W           = 32;
    localparam int RESULT_W          = 64;

    typedef struct packed {
        logic start;
        logic wide;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

// ===== rtl/crtpc_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
`include "assert_macros.svh"

module crtpc_div
    import crtpc_pkg::*;
#(
    parameter int MODULUS_WIDTH = MODULUS_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_div_req                   i_req,
    input  logic [2*MODULUS_WIDTH-1:0] i_dividend,
    input  logic [MODULUS_WIDTH-1:0]   i_divisor,
    output t_div_rsp                   o_rsp,
    output logic [MODULUS_WIDTH-1:0]   o_quotient,
    output logic [MODULUS_WIDTH-1:0]   o_remainder
);

    localparam int W     = MODULUS_WIDTH;
    localparam int DW    = 2 * W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;
    logic [DW-1:0]    r_dvd;

    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.wide ? CNT_W'(DW) : CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.wide ? i_dividend : {i_dividend[W-1:0], {W{1'b0}}};
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            r_dvd <= {r_dvd[DW-2:0], w_ge};
        end
    end

    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_done;
    assign o_quotient  = r_dvd[W-1:0];
    assign o_remainder = r_rem;

    `CRT_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy), "done without busy")
    `CRT_ASSERT(a_busy_count, i_clk, i_rst_n, r_busy |-> r_cnt != '0, "busy with empty count")

endmodule

// ===== rtl/crt_pair_combine.sv =====
// Chinese remainder combiner of two congruences: extended Euclid plus modular reduction.
// Euclid runs n steps, at most 46 for W = 32 (W = MODULUS_WIDTH); each step waits on the divider.
// A zero modulus skips Euclid and goes from idle straight to the done state. One item at a time:
// o_stall is high from accept until the result enters the output register.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
`include "assert_macros.svh"

module crt_pair_combine
    import crtpc_pkg::*;
#(
    parameter int MODULUS_WIDTH = MODULUS_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [FIELD_W-1:0]  i_old_modulus,
    input  logic [FIELD_W-1:0]  i_old_residue,
    input  logic [FIELD_W-1:0]  i_new_modulus,
    input  logic [FIELD_W-1:0]  i_new_residue,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [RESULT_W-1:0] o_combined_modulus,
    output logic [RESULT_W-1:0] o_combined_residue
);

    localparam int W  = MODULUS_WIDTH;
    localparam int DW = 2 * W;
    localparam int MW = W + 2;

    typedef enum logic [16:0] {
        S_IDLE = 17'b00000000000000001,
        S_PROD = 17'b00000000000000010,
        S_ECHK = 17'b00000000000000100,
        S_EDIV = 17'b00000000000001000,
        S_EMX  = 17'b00000000000010000,
        S_EMY  = 17'b00000000000100000,
        S_EUY  = 17'b00000000001000000,
        S_M1   = 17'b00000000010000000,
        S_D1   = 17'b00000000100000000,
        S_W1   = 17'b00000001000000000,
        S_M2   = 17'b00000010000000000,
        S_D2   = 17'b00000100000000000,
        S_W2   = 17'b00001000000000000,
        S_C1   = 17'b00010000000000000,
        S_C2   = 17'b00100000000000000,
        S_C3   = 17'b01000000000000000,
        S_DONE = 17'b10000000000000000
    } t_state;

    t_state                r_state;
    t_state                n_state;

    logic [W-1:0]          r_m1;
    logic [W-1:0]          r_r1;
    logic [W-1:0]          r_m2;
    logic [W-1:0]          r_r2;
    logic [W-1:0]          r_a;
    logic [W-1:0]          r_b;
    logic [MW-1:0]         r_x0;
    logic [MW-1:0]         r_x1;
    logic [MW-1:0]         r_y0;
    logic [MW-1:0]         r_y1;
    logic [W-1:0]          r_t1;
    logic [W-1:0]          r_t2;
    logic [DW-1:0]         r_mul;
    logic [DW:0]           r_sum;
    logic [DW-1:0]         r_mod;
    logic                  r_out_valid;
    logic [RESULT_W-1:0]   r_out_mod;
    logic [RESULT_W-1:0]   r_out_res;

    logic                  w_out_free;
    logic                  w_zero_in;
    logic [W-1:0]          w_a1m;
    logic [W-1:0]          w_a2m;
    logic signed [MW-1:0]  w_ma;
    logic signed [MW-1:0]  w_mb;
    logic signed [2*MW-1:0] w_prod;
    logic [DW:0]           w_diff;
    logic [DW-1:0]         w_res;

    t_div_req              div_req;
    t_div_rsp              div_rsp;
    logic [DW-1:0]         w_dvd;
    logic [W-1:0]          w_dvs;
    logic [W-1:0]          w_quot;
    logic [W-1:0]          w_rem;

    assign o_stall    = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_zero_in  = (i_old_modulus[W-1:0] == '0) || (i_new_modulus[W-1:0] == '0);

    // Bring the final Bezout coefficients into 0..modulus.
    assign w_a1m = r_x0[MW-1] ? (r_x0[W-1:0] + r_m2) : r_x0[W-1:0];
    assign w_a2m = r_y0[MW-1] ? (r_y0[W-1:0] + r_m1) : r_y0[W-1:0];

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_PROD: begin
                w_ma = MW'(r_m1);
                w_mb = MW'(r_m2);
            end
            S_EMX: begin
                w_ma = MW'(w_quot);
                w_mb = r_x1;
            end
            S_EMY: begin
                w_ma = MW'(w_quot);
                w_mb = r_y1;
            end
            S_M1: begin
                w_ma = MW'(r_r1);
                w_mb = MW'(w_a2m);
            end
            S_M2: begin
                w_ma = MW'(r_r2);
                w_mb = MW'(w_a1m);
            end
            S_C1: begin
                w_ma = MW'(r_m2);
                w_mb = MW'(r_t1);
            end
            S_C2: begin
                w_ma = MW'(r_m1);
                w_mb = MW'(r_t2);
            end
            default: ;
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        div_req.start = 1'b0;
        div_req.wide  = 1'b0;
        w_dvd         = r_mul;
        w_dvs         = r_b;
        case (r_state)
            S_ECHK: begin
                div_req.start = (r_b != '0);
                w_dvd         = DW'(r_a);
            end
            S_D1: begin
                div_req.start = 1'b1;
                div_req.wide  = 1'b1;
                w_dvs         = r_m1;
            end
            S_D2: begin
                div_req.start = 1'b1;
                div_req.wide  = 1'b1;
                w_dvs         = r_m2;
            end
            default: ;
        endcase
    end

    crtpc_div #(
        .MODULUS_WIDTH (MODULUS_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (div_req),
        .i_dividend  (w_dvd),
        .i_divisor   (w_dvs),
        .o_rsp       (div_rsp),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = w_zero_in ? S_DONE : S_PROD;
                end
            end
            S_PROD: n_state = S_ECHK;
            S_ECHK: n_state = (r_b == '0) ? S_M1 : S_EDIV;
            S_EDIV: begin
                if (div_rsp.done) begin
                    n_state = S_EMX;
                end
            end
            S_EMX:  n_state = S_EMY;
            S_EMY:  n_state = S_EUY;
            S_EUY:  n_state = S_ECHK;
            S_M1:   n_state = S_D1;
            S_D1:   n_state = S_W1;
            S_W1: begin
                if (div_rsp.done) begin
                    n_state = S_M2;
                end
            end
            S_M2:   n_state = S_D2;
            S_D2:   n_state = S_W2;
            S_W2: begin
                if (div_rsp.done) begin
                    n_state = S_C1;
                end
            end
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_C3;
            S_C3:   n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= w_prod[DW-1:0];
        case (r_state)
            S_IDLE: begin
                r_m1  <= i_old_modulus[W-1:0];
                r_r1  <= i_old_residue[W-1:0];
                r_m2  <= i_new_modulus[W-1:0];
                r_r2  <= i_new_residue[W-1:0];
                r_a   <= i_old_modulus[W-1:0];
                r_b   <= i_new_modulus[W-1:0];
                r_x0  <= MW'(1);
                r_x1  <= '0;
                r_y0  <= '0;
                r_y1  <= MW'(1);
                r_sum <= '0;
                r_mod <= '0;
            end
            S_PROD: r_mod <= w_prod[DW-1:0];
            S_EMY: begin
                r_x1 <= r_x0 - r_mul[MW-1:0];
                r_x0 <= r_x1;
            end
            S_EUY: begin
                r_y1 <= r_y0 - r_mul[MW-1:0];
                r_y0 <= r_y1;
                r_a  <= r_b;
                r_b  <= w_rem;
            end
            S_W1: begin
                if (div_rsp.done) begin
                    r_t1 <= w_rem;
                end
            end
            S_W2: begin
                if (div_rsp.done) begin
                    r_t2 <= w_rem;
                end
            end
            S_C2:   r_sum <= {1'b0, r_mul};
            S_C3:   r_sum <= r_sum + {1'b0, r_mul};
            default: ;
        endcase
    end

    assign w_diff = r_sum - {1'b0, r_mod};
    assign w_res  = w_diff[DW] ? r_sum[DW-1:0] : w_diff[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_mod <= RESULT_W'(r_mod);
            r_out_res <= RESULT_W'(w_res);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_combined_modulus = r_out_mod;
    assign o_combined_residue = r_out_res;

    `CRT_ASSERT(a_res_below_mod, i_clk, i_rst_n,
        o_valid && o_combined_modulus != '0 |-> o_combined_residue < o_combined_modulus,
        "residue not below modulus")
    `CRT_ASSERT(a_zero_mod_res, i_clk, i_rst_n,
        o_valid && o_combined_modulus == '0 |-> o_combined_residue == '0,
        "nonzero residue for zero modulus")
    `CRT_ASSERT_NEVER(a_div_overlap, i_clk, i_rst_n, div_req.start && div_rsp.busy,
        "divider restarted while busy")
    `CRT_ASSERT(a_div_nonzero, i_clk, i_rst_n, div_req.start |-> w_dvs != '0,
        "division by zero issued")

endmodule
